@@ src/cdlc_pkg.sv @@
// ----------------------------------------------------------------------------
// cdlc_pkg: shared types and constants of the ChaCha differential-linear counter
// Holds the state type, ChaCha constants, quarter-round index helpers,
// output bit masks, register indexes and command codes.
// ----------------------------------------------------------------------------
package cdlc_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_WORDS  = 16;
   localparam int STATE_W    = WORD_W * NUM_WORDS;

   typedef logic [WORD_W-1:0]                 word_type;
   typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  state_type;

   // Pipeline layout: one column round on the sample, then a diagonal and a
   // column round on both copies. Each round takes four cell stages.
   localparam int ROUND_STEPS  = 4;
   localparam int NUM_STAGES   = 3 * ROUND_STEPS;
   localparam int SPLIT_STAGE  = ROUND_STEPS;

   localparam int COUNT_WIDTH_DEF = 40;
   localparam int ZEROS_W         = 40;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_1     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2_3     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_4_5     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_6_7     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_3_7    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_11_15  = 3'd5;

   localparam logic [CSR_DATA_W-1:0] DIFF_3_7_RST   = 64'h0000_2002_0010_0010;
   localparam logic [CSR_DATA_W-1:0] DIFF_11_15_RST = 64'h2000_0002_2020_0000;

   localparam logic CMD_TEST  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 88;

   localparam word_type SIGMA_0 = 32'h6170_7865;
   localparam word_type SIGMA_1 = 32'h3320_646e;
   localparam word_type SIGMA_2 = 32'h7962_2d32;
   localparam word_type SIGMA_3 = 32'h6b20_6574;

   // Quarter-round roles.
   localparam int ROLE_A = 0;
   localparam int ROLE_B = 1;
   localparam int ROLE_C = 2;
   localparam int ROLE_D = 3;

   // Control handed from the pipeline to the counter stage.
   typedef struct packed {
      logic load;
      logic clear;
      logic par_first;
      logic par_second;
   } tally_ctrl_type;

   function automatic int rot_amt(input int step);
      case (step)
         0: return 16;
         1: return 12;
         2: return 8;
         default: return 7;
      endcase
   endfunction

   // State word that plays a role in quarter q of a column or diagonal round.
   function automatic int qr_index(input bit diag, input int q, input int role);
      if (diag) begin
         return role * 4 + ((q + role) & 3);
      end else begin
         return role * 4 + q;
      end
   endfunction

   function automatic state_type mask_first();
      state_type m;
      m = '0;
      m[7][0]  = 1'b1;
      m[7][3]  = 1'b1;
      m[7][4]  = 1'b1;
      m[7][20] = 1'b1;
      return m;
   endfunction

   function automatic state_type mask_second();
      state_type m;
      m = '0;
      m[2][0]  = 1'b1;
      m[2][2]  = 1'b1;
      m[2][4]  = 1'b1;
      m[8][20] = 1'b1;
      m[13][3] = 1'b1;
      m[13][4] = 1'b1;
      return m;
   endfunction

endpackage

@@ src/cdlc_cell.sv @@
// ----------------------------------------------------------------------------
// cdlc_cell: one quarter-round step over all four quarters of a ChaCha round
// Performs x += y; z = rotl(z ^ x) on four independent quarters and
// registers the whole state for the next cell.
// ----------------------------------------------------------------------------
module cdlc_cell
   import cdlc_pkg::*;
#(
   parameter int STEP = 0,
   parameter bit DIAG = 1'b0
) (
   input  logic      clock,
   input  logic      load,
   input  state_type state_in,
   output state_type state_out
);

   localparam int ROT    = rot_amt(STEP);
   localparam int ROLE_X = (STEP % 2 == 0) ? ROLE_A : ROLE_C;
   localparam int ROLE_Y = (STEP % 2 == 0) ? ROLE_B : ROLE_D;
   localparam int ROLE_Z = (STEP % 2 == 0) ? ROLE_D : ROLE_B;

   state_type state_ff;
   state_type state_step_in;

   always_comb begin
      word_type sum;
      word_type mix;
      state_step_in = state_in;
      for (int q = 0; q < 4; q++) begin
         sum = state_in[qr_index(DIAG, q, ROLE_X)] + state_in[qr_index(DIAG, q, ROLE_Y)];
         mix = state_in[qr_index(DIAG, q, ROLE_Z)] ^ sum;
         state_step_in[qr_index(DIAG, q, ROLE_X)] = sum;
         state_step_in[qr_index(DIAG, q, ROLE_Z)] = (mix << ROT) | (mix >> (WORD_W - ROT));
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         state_ff <= state_step_in;
      end
   end

   assign state_out = state_ff;

endmodule

@@ src/cdlc_tally.sv @@
// ----------------------------------------------------------------------------
// cdlc_tally: saturating zero-parity counters and the result register
// Updates both counters as an item leaves the cell chain and holds the
// result until the consumer takes it.
// ----------------------------------------------------------------------------
module cdlc_tally
   import cdlc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tally_ctrl_type       ctrl,
   input  logic                 take,
   output logic                 ready,
   output logic                 out_valid,
   output logic                 out_par_first,
   output logic                 out_par_second,
   output logic [ZEROS_W-1:0]   out_zeros_first,
   output logic [ZEROS_W-1:0]   out_zeros_second
);

   logic [COUNT_WIDTH-1:0] tally_first_ff, tally_first_in;
   logic [COUNT_WIDTH-1:0] tally_second_ff, tally_second_in;
   logic                   vld_ff, vld_in;
   logic                   par_first_ff, par_second_ff;
   logic [ZEROS_W-1:0]     zeros_first_ff, zeros_second_ff;

   assign ready = !vld_ff || take;

   // A counter that is full stays full until a clear item zeroes it.
   always_comb begin
      tally_first_in  = tally_first_ff;
      tally_second_in = tally_second_ff;
      if (ctrl.clear == CMD_CLEAR) begin
         tally_first_in  = '0;
         tally_second_in = '0;
      end else begin
         if (!ctrl.par_first && (tally_first_ff != '1)) begin
            tally_first_in = tally_first_ff + COUNT_WIDTH'(1);
         end
         if (!ctrl.par_second && (tally_second_ff != '1)) begin
            tally_second_in = tally_second_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (ctrl.load) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_first_ff  <= '0;
         tally_second_ff <= '0;
         vld_ff          <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (ctrl.load) begin
            tally_first_ff  <= tally_first_in;
            tally_second_ff <= tally_second_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         par_first_ff    <= (ctrl.clear == CMD_CLEAR) ? 1'b0 : ctrl.par_first;
         par_second_ff   <= (ctrl.clear == CMD_CLEAR) ? 1'b0 : ctrl.par_second;
         zeros_first_ff  <= ZEROS_W'(tally_first_in);
         zeros_second_ff <= ZEROS_W'(tally_second_in);
      end
   end

   assign out_valid        = vld_ff;
   assign out_par_first    = par_first_ff;
   assign out_par_second   = par_second_ff;
   assign out_zeros_first  = zeros_first_ff;
   assign out_zeros_second = zeros_second_ff;

endmodule

@@ src/chacha_diff_linear_counter_top.sv @@
// ----------------------------------------------------------------------------
// chacha_diff_linear_counter_top: differential-linear sampling counter
// Runs three ChaCha rounds on a nonce, the last two also on a differenced
// copy, and counts zero parities of two output masks.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side does not
// stall and returns one result item for each, in order, through twelve
// cell stages, each doing one add-xor-rotate step of all four
// quarter-rounds, and one counter and result register. The cell chain
// moves forward stage by stage, so an item enters as long as there is a free
// slot anywhere ahead of it. Key and input difference registers are written
// through the csr_ port and must only change while no item is in flight. A
// clear item zeroes both counters and returns an all-zero result.
module chacha_diff_linear_counter_top
   import cdlc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // nonce_word_0 [31:0], nonce_word_1 [63:32], nonce_word_2 [95:64],
   // nonce_word_3 [127:96]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // command [0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // parity_first [0], parity_second [1], zeros_first [41:2],
   // zeros_second [81:42], zero fill [87:82]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CSR_DATA_W-1:0] key_0_1_ff, key_2_3_ff, key_4_5_ff, key_6_7_ff;
   logic [CSR_DATA_W-1:0] diff_3_7_ff, diff_11_15_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_1_ff    <= '0;
         key_2_3_ff    <= '0;
         key_4_5_ff    <= '0;
         key_6_7_ff    <= '0;
         diff_3_7_ff   <= DIFF_3_7_RST;
         diff_11_15_ff <= DIFF_11_15_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_0_1:    key_0_1_ff    <= csr_wdata;
            CSR_KEY_2_3:    key_2_3_ff    <= csr_wdata;
            CSR_KEY_4_5:    key_4_5_ff    <= csr_wdata;
            CSR_KEY_6_7:    key_6_7_ff    <= csr_wdata;
            CSR_DIFF_3_7:   diff_3_7_ff   <= csr_wdata;
            CSR_DIFF_11_15: diff_11_15_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type init_state;
   state_type diff_state;

   always_comb begin
      init_state     = '0;
      init_state[0]  = SIGMA_0;
      init_state[1]  = SIGMA_1;
      init_state[2]  = SIGMA_2;
      init_state[3]  = SIGMA_3;
      init_state[4]  = key_0_1_ff[63:32];
      init_state[5]  = key_0_1_ff[31:0];
      init_state[6]  = key_2_3_ff[63:32];
      init_state[7]  = key_2_3_ff[31:0];
      init_state[8]  = key_4_5_ff[63:32];
      init_state[9]  = key_4_5_ff[31:0];
      init_state[10] = key_6_7_ff[63:32];
      init_state[11] = key_6_7_ff[31:0];
      init_state[12] = req_tdata[31:0];
      init_state[13] = req_tdata[63:32];
      init_state[14] = req_tdata[95:64];
      init_state[15] = req_tdata[127:96];
   end

   always_comb begin
      diff_state     = '0;
      diff_state[3]  = diff_3_7_ff[63:32];
      diff_state[7]  = diff_3_7_ff[31:0];
      diff_state[11] = diff_11_15_ff[63:32];
      diff_state[15] = diff_11_15_ff[31:0];
   end

   // Stage control: a stage loads when it is empty or its item moves on.
   logic                  vld_ff [NUM_STAGES];
   logic                  vld_in [NUM_STAGES];
   logic                  cmd_ff [NUM_STAGES];
   logic [NUM_STAGES:0]   rdy;
   state_type             sa [NUM_STAGES];
   state_type             sb [NUM_STAGES];
   tally_ctrl_type        tctl;
   logic                  tally_ready;

   assign rdy[NUM_STAGES] = tally_ready;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      assign rdy[i] = !vld_ff[i] || rdy[i+1];

      if (i == 0) begin : g_first
         assign vld_in[i] = req_tvalid;
         cdlc_cell #(.STEP(i % ROUND_STEPS), .DIAG(1'b0)) u_cell_a (
            .clock     (clock),
            .load      (rdy[i]),
            .state_in  (init_state),
            .state_out (sa[i])
         );
         always_ff @(posedge clock) begin
            if (rdy[i]) begin
               cmd_ff[i] <= req_tuser;
            end
         end
      end else begin : g_next
         assign vld_in[i] = vld_ff[i-1];
         cdlc_cell #(
            .STEP (i % ROUND_STEPS),
            .DIAG ((i / ROUND_STEPS) == 1)
         ) u_cell_a (
            .clock     (clock),
            .load      (rdy[i]),
            .state_in  (sa[i-1]),
            .state_out (sa[i])
         );
         always_ff @(posedge clock) begin
            if (rdy[i]) begin
               cmd_ff[i] <= cmd_ff[i-1];
            end
         end
      end

      // The differenced copy splits off after the first column round.
      if (i == SPLIT_STAGE) begin : g_split
         cdlc_cell #(.STEP(i % ROUND_STEPS), .DIAG(1'b1)) u_cell_b (
            .clock     (clock),
            .load      (rdy[i]),
            .state_in  (sa[i-1] ^ diff_state),
            .state_out (sb[i])
         );
      end else if (i > SPLIT_STAGE) begin : g_copy
         cdlc_cell #(
            .STEP (i % ROUND_STEPS),
            .DIAG ((i / ROUND_STEPS) == 1)
         ) u_cell_b (
            .clock     (clock),
            .load      (rdy[i]),
            .state_in  (sb[i-1]),
            .state_out (sb[i])
         );
      end else begin : g_none
         assign sb[i] = '0;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vld_in[i];
         end
      end
   end

   assign req_tready = rdy[0];

   state_type out_diff;
   assign out_diff = sa[NUM_STAGES-1] ^ sb[NUM_STAGES-1];

   always_comb begin
      tctl.load       = vld_ff[NUM_STAGES-1] && tally_ready;
      tctl.clear      = cmd_ff[NUM_STAGES-1];
      tctl.par_first  = ^(out_diff & mask_first());
      tctl.par_second = ^(out_diff & mask_second());
   end

   logic               par_first, par_second;
   logic [ZEROS_W-1:0] zeros_first, zeros_second;

   cdlc_tally #(.COUNT_WIDTH(COUNT_WIDTH)) u_tally (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (tctl),
      .take             (rsp_tready),
      .ready            (tally_ready),
      .out_valid        (rsp_tvalid),
      .out_par_first    (par_first),
      .out_par_second   (par_second),
      .out_zeros_first  (zeros_first),
      .out_zeros_second (zeros_second)
   );

   assign rsp_tdata = {6'd0, zeros_second, zeros_first, par_second, par_first};

   // An empty result register means every stage can take an item.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input not ready while result register is empty");

   // A clear item yields an all-zero result.
   a_clear_zeroes : assert property (@(posedge clock) disable iff (reset)
      (tctl.load && tctl.clear) |=> (rsp_tdata == '0))
      else $error("clear item did not give a zero result");

   // An item leaving the chain is presented on the result side next cycle.
   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      tctl.load |=> rsp_tvalid)
      else $error("result lost after leaving the cell chain");

endmodule
